@@ rtl/core/vna_pkg.sv @@
// Package for the vertex normal accumulator: item types, commands, FSM states.
// Used by every module under rtl/core; depends on nothing.
package vna_pkg;

	localparam int VERTEX_COUNT_DEF = 1024;
	localparam int IDX_W = 10;
	localparam int POS_W = 16;
	localparam int ACC_W = 48;
	localparam int NRM_W = 16;
	localparam int ONE_Q14 = 16384;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_TRI   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]              command;
		logic [IDX_W-1:0]        index_a;
		logic [IDX_W-1:0]        index_b;
		logic [IDX_W-1:0]        index_c;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    defaulted;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_TRI_RD_A,
		ST_TRI_RD_B,
		ST_TRI_RD_C,
		ST_TRI_EDGE,
		ST_TRI_MUL,
		ST_TRI_SUM,
		ST_TRI_ACC_RD,
		ST_TRI_ACC_WR,
		ST_RD_ACC,
		ST_RD_MAG,
		ST_RD_SHIFT,
		ST_RD_SQ,
		ST_RD_SUM,
		ST_RD_SQRT,
		ST_RD_DIV,
		ST_RD_DONE,
		ST_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic       load_item;
		logic       clr_step;
		logic       pos_wr;
		logic       acc_clr_wr;
		logic [1:0] corner;
		logic       pos_rd;
		logic       edge_calc;
		logic       mul_calc;
		logic       sum_calc;
		logic       acc_rd;
		logic       acc_wr;
		logic       mag_calc;
		logic       shift_step;
		logic       sq_calc;
		logic       sqsum_calc;
		logic       sqrt_step;
		logic       div_start;
		logic       div_step;
		logic       finish_read;
		logic       result_zero;
	} ctl_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic clr_done;
		logic idx_ok_a;
		logic tri_ok;
		logic acc_zero;
		logic shift_done;
		logic sqrt_done;
		logic div_done;
	} sts_t;

endpackage

@@ rtl/core/vna_ctrl.sv @@
// Controller state machine for the vertex normal accumulator.
// Depends on vna_pkg; drives datapath commands from datapath status.
module vna_ctrl
	import vna_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] in_cmd,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic [1:0] corner_q, corner_d;
	logic [1:0] cmd_q;

	// Command held for the item in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_NOP;
		end else if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= in_cmd;
		end
	end

	// State and corner counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			corner_q <= '0;
		end else begin
			state_q  <= state_d;
			corner_q <= corner_d;
		end
	end

	// Next state.
	always_comb begin
		state_d  = state_q;
		corner_d = corner_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_WRITE: state_d = ST_WRITE;
						CMD_TRI:   state_d = ST_TRI_RD_A;
						CMD_READ:  state_d = ST_RD_ACC;
						default:   state_d = ST_OUT;
					endcase
				end
			end
			ST_WRITE:    state_d = ST_OUT;
			ST_TRI_RD_A: state_d = sts.tri_ok ? ST_TRI_RD_B : ST_OUT;
			ST_TRI_RD_B: state_d = ST_TRI_RD_C;
			ST_TRI_RD_C: state_d = ST_TRI_EDGE;
			ST_TRI_EDGE: state_d = ST_TRI_MUL;
			ST_TRI_MUL:  state_d = ST_TRI_SUM;
			ST_TRI_SUM: begin
				state_d  = ST_TRI_ACC_RD;
				corner_d = '0;
			end
			ST_TRI_ACC_RD: state_d = ST_TRI_ACC_WR;
			ST_TRI_ACC_WR: begin
				if (corner_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					corner_d = corner_q + 2'd1;
					state_d  = ST_TRI_ACC_RD;
				end
			end
			ST_RD_ACC: state_d = sts.idx_ok_a ? ST_RD_MAG : ST_OUT;
			ST_RD_MAG: state_d = sts.acc_zero ? ST_RD_DONE : ST_RD_SHIFT;
			ST_RD_SHIFT: if (sts.shift_done) state_d = ST_RD_SQ;
			ST_RD_SQ:    state_d = ST_RD_SUM;
			ST_RD_SUM:   state_d = ST_RD_SQRT;
			ST_RD_SQRT:  if (sts.sqrt_done) state_d = ST_RD_DIV;
			ST_RD_DIV:   if (sts.div_done) state_d = ST_RD_DONE;
			ST_RD_DONE:  state_d = ST_OUT;
			ST_OUT:      if (!out_stall) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctl = '0;
		ctl.corner = corner_q;
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		case (state_q)
			ST_IDLE: begin
				ctl.load_item  = in_valid;
				ctl.result_zero = in_valid;
			end
			ST_CLEAR: ctl.clr_step = 1'b1;
			ST_WRITE: begin
				ctl.pos_wr     = 1'b1;
				ctl.acc_clr_wr = 1'b1;
			end
			ST_TRI_RD_A: begin
				ctl.pos_rd = 1'b1;
				ctl.corner = 2'd0;
			end
			ST_TRI_RD_B: begin
				ctl.pos_rd = 1'b1;
				ctl.corner = 2'd1;
			end
			ST_TRI_RD_C: begin
				ctl.pos_rd = 1'b1;
				ctl.corner = 2'd2;
			end
			ST_TRI_EDGE:   ctl.edge_calc = 1'b1;
			ST_TRI_MUL:    ctl.mul_calc = 1'b1;
			ST_TRI_SUM:    ctl.sum_calc = 1'b1;
			ST_TRI_ACC_RD: ctl.acc_rd = 1'b1;
			ST_TRI_ACC_WR: ctl.acc_wr = 1'b1;
			ST_RD_ACC: begin
				ctl.acc_rd = 1'b1;
				ctl.corner = 2'd0;
			end
			ST_RD_MAG:   ctl.mag_calc = 1'b1;
			ST_RD_SHIFT: ctl.shift_step = 1'b1;
			ST_RD_SQ:    ctl.sq_calc = 1'b1;
			ST_RD_SUM:   ctl.sqsum_calc = 1'b1;
			ST_RD_SQRT: begin
				ctl.sqrt_step = 1'b1;
				ctl.div_start = sts.sqrt_done;
			end
			ST_RD_DIV:  ctl.div_step = 1'b1;
			ST_RD_DONE: ctl.finish_read = (cmd_q == CMD_READ);
			default: ;
		endcase
	end

endmodule

@@ rtl/core/vna_dp.sv @@
// Datapath of the vertex normal accumulator: position and accumulator memories,
// cross product, square root and divider units. Depends on vna_pkg.
module vna_dp
	import vna_pkg::*;
#(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  ctl_t      ctl,
	output sts_t      sts,
	output out_item_t out_item
);

	localparam int AW = IDX_W;
	localparam int CLR_W = $clog2(VERTEX_COUNT + 1);

	// Memories: positions and accumulators (all three axes in one word).
	logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
	logic [3*ACC_W-1:0] acc_mem [VERTEX_COUNT];

	in_item_t item_q;
	logic [CLR_W-1:0] clr_q;
	logic [3*POS_W-1:0] pos_rd_q;
	logic [3*ACC_W-1:0] acc_rd_q;
	logic signed [POS_W-1:0] pa_q [3];
	logic signed [POS_W-1:0] pb_q [3];
	logic signed [POS_W:0] e0_q [3];
	logic signed [POS_W:0] e1_q [3];
	logic signed [2*POS_W+1:0] pr_q [6];
	logic signed [ACC_W-1:0] cr_q [3];
	logic [1:0] rd_phase_q;
	logic [AW-1:0] acc_idx;
	logic [AW-1:0] pos_idx;
	out_item_t   out_q;

	// Normalization registers.
	logic [ACC_W-1:0] mag_q [3];
	logic             pos_sign_q [3];
	logic [59:0]      sq_q [3];
	logic [61:0]      rem_q;
	logic [61:0]      root_q;
	logic [61:0]      bit_q;
	logic [5:0]       sqrt_cnt_q;
	logic [1:0]       div_k_q;
	logic [44:0]      dividend_q;
	logic [30:0]      len_q;
	logic [44:0]      quot_q;
	logic [5:0]       div_cnt_q;
	logic [14:0]      nval_q [3];

	function automatic logic idx_valid(input logic [AW-1:0] i);
		return int'({1'b0, i}) < VERTEX_COUNT;
	endfunction

	// Item register and clear counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_step) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) item_q <= in_item;
	end

	// Address selection by corner.
	always_comb begin
		case (ctl.corner)
			2'd1:    pos_idx = item_q.index_b;
			2'd2:    pos_idx = item_q.index_c;
			default: pos_idx = item_q.index_a;
		endcase
		acc_idx = pos_idx;
	end

	// Position memory.
	always_ff @(posedge clk) begin
		if (ctl.pos_wr && idx_valid(item_q.index_a)) begin
			pos_mem[item_q.index_a] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
		end
		if (ctl.pos_rd) pos_rd_q <= pos_mem[pos_idx];
	end

	// Accumulator memory with clearing pass after reset.
	always_ff @(posedge clk) begin
		if (ctl.clr_step && clr_q < CLR_W'(VERTEX_COUNT)) begin
			acc_mem[clr_q[AW-1:0]] <= '0;
		end else if (ctl.acc_clr_wr && idx_valid(item_q.index_a)) begin
			acc_mem[item_q.index_a] <= '0;
		end else if (ctl.acc_wr) begin
			acc_mem[acc_idx] <= {acc_rd_q[3*ACC_W-1:2*ACC_W] + cr_q[0],
			                     acc_rd_q[2*ACC_W-1:ACC_W] + cr_q[1],
			                     acc_rd_q[ACC_W-1:0] + cr_q[2]};
		end
		if (ctl.acc_rd) acc_rd_q <= acc_mem[acc_idx];
	end

	// Triangle: gather corners and compute edges, products, cross product.
	always_ff @(posedge clk) begin
		if (ctl.pos_rd) rd_phase_q <= ctl.corner;
		if (ctl.pos_rd || ctl.edge_calc) begin
			if (rd_phase_q == 2'd0 && ctl.corner == 2'd1) begin
				for (int k = 0; k < 3; k++)
					pa_q[k] <= pos_rd_q[(2-k)*POS_W +: POS_W];
			end
			if (rd_phase_q == 2'd1 && ctl.corner == 2'd2) begin
				for (int k = 0; k < 3; k++)
					pb_q[k] <= pos_rd_q[(2-k)*POS_W +: POS_W];
			end
		end
		if (ctl.edge_calc) begin
			for (int k = 0; k < 3; k++) begin
				e0_q[k] <= (POS_W+1)'(pb_q[k]) - (POS_W+1)'(pa_q[k]);
				e1_q[k] <= (POS_W+1)'($signed(pos_rd_q[(2-k)*POS_W +: POS_W]))
				           - (POS_W+1)'(pa_q[k]);
			end
		end
		if (ctl.mul_calc) begin
			pr_q[0] <= (2*POS_W+2)'(e0_q[1] * e1_q[2]);
			pr_q[1] <= (2*POS_W+2)'(e0_q[2] * e1_q[1]);
			pr_q[2] <= (2*POS_W+2)'(e0_q[2] * e1_q[0]);
			pr_q[3] <= (2*POS_W+2)'(e0_q[0] * e1_q[2]);
			pr_q[4] <= (2*POS_W+2)'(e0_q[0] * e1_q[1]);
			pr_q[5] <= (2*POS_W+2)'(e0_q[1] * e1_q[0]);
		end
		if (ctl.sum_calc) begin
			cr_q[0] <= ACC_W'(pr_q[0]) - ACC_W'(pr_q[1]);
			cr_q[1] <= ACC_W'(pr_q[2]) - ACC_W'(pr_q[3]);
			cr_q[2] <= ACC_W'(pr_q[4]) - ACC_W'(pr_q[5]);
		end
	end

	// Read: magnitudes, scaling shift and squares.
	always_ff @(posedge clk) begin
		if (ctl.mag_calc) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [ACC_W-1:0] c;
				c = acc_rd_q[(2-k)*ACC_W +: ACC_W];
				mag_q[k]      <= c[ACC_W-1] ? ACC_W'(-c) : c;
				pos_sign_q[k] <= !c[ACC_W-1] && (c != '0);
			end
		end else if (ctl.shift_step && !sts.shift_done) begin
			for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
		end
		if (ctl.sq_calc) begin
			for (int k = 0; k < 3; k++)
				sq_q[k] <= 60'(mag_q[k][29:0] * mag_q[k][29:0]);
		end
	end

	assign sts.shift_done = ((mag_q[0] | mag_q[1] | mag_q[2]) >> 30) == '0;

	// Sum of squares, then bit-pair square root, one result bit per cycle.
	always_ff @(posedge clk) begin
		if (ctl.sqsum_calc) begin
			rem_q      <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
			root_q     <= '0;
			bit_q      <= 62'(1) << 60;
			sqrt_cnt_q <= 6'd31;
		end else if (ctl.sqrt_step && sqrt_cnt_q != '0) begin
			if ({1'b0, rem_q} >= {1'b0, bit_q} + {1'b0, root_q}) begin
				rem_q  <= rem_q - (bit_q + root_q);
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q      <= bit_q >> 2;
			sqrt_cnt_q <= sqrt_cnt_q - 6'd1;
		end
	end

	assign sts.sqrt_done = (sqrt_cnt_q == '0);

	// Restoring divider, one quotient bit per cycle, three components in turn.
	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			len_q      <= (root_q == '0) ? 31'd1 : 31'(root_q);
			div_k_q    <= '0;
			dividend_q <= 45'({mag_q[0][29:0], 14'b0}) + 45'((root_q == '0) ? 0 : root_q >> 1);
			quot_q     <= '0;
			div_cnt_q  <= 6'd45;
		end else if (ctl.div_step && !sts.div_done) begin
			if (div_cnt_q != '0) begin
				logic [75:0] part;
				part = {31'b0, dividend_q} >> (div_cnt_q - 6'd1);
				if (part >= {45'b0, len_q}) begin
					dividend_q <= dividend_q - 45'(({14'b0, len_q}) << (div_cnt_q - 6'd1));
					quot_q[div_cnt_q - 6'd1] <= 1'b1;
				end
				div_cnt_q <= div_cnt_q - 6'd1;
			end else begin
				nval_q[div_k_q] <= (quot_q > 45'(ONE_Q14)) ? 15'(ONE_Q14 - 1) + 15'd1
				                   : quot_q[14:0];
				div_k_q    <= div_k_q + 2'd1;
				dividend_q <= 45'({mag_q[(div_k_q == 2'd0) ? 1 : 2][29:0], 14'b0})
				              + 45'(len_q >> 1);
				quot_q     <= '0;
				div_cnt_q  <= 6'd45;
			end
		end
	end

	assign sts.div_done = (div_k_q == 2'd3);

	// Result register.
	always_ff @(posedge clk) begin
		if (ctl.result_zero) begin
			out_q <= '0;
		end else if (ctl.finish_read) begin
			if (sts.acc_zero) begin
				out_q <= '{normal_x: '0, normal_y: '0,
				           normal_z: NRM_W'(ONE_Q14), defaulted: 1'b1};
			end else begin
				out_q.normal_x  <= pos_sign_q[0] ? -NRM_W'({1'b0, nval_q[0]}) : NRM_W'({1'b0, nval_q[0]});
				out_q.normal_y  <= pos_sign_q[1] ? -NRM_W'({1'b0, nval_q[1]}) : NRM_W'({1'b0, nval_q[1]});
				out_q.normal_z  <= pos_sign_q[2] ? -NRM_W'({1'b0, nval_q[2]}) : NRM_W'({1'b0, nval_q[2]});
				out_q.defaulted <= 1'b0;
			end
		end
	end

	assign out_item     = out_q;
	assign sts.clr_done = (clr_q >= CLR_W'(VERTEX_COUNT));
	assign sts.idx_ok_a = idx_valid(item_q.index_a);
	assign sts.tri_ok   = idx_valid(item_q.index_a) && idx_valid(item_q.index_b)
	                      && idx_valid(item_q.index_c);
	assign sts.acc_zero = (acc_rd_q == '0);

endmodule

@@ rtl/core/vertex_normal_accumulator.sv @@
// Vertex normal accumulator: top level joining controller and datapath.
// Steps from input item to result item: a read makes up to 18 scaling shifts, a square
// root, then a divider pass for each of three components in turn; a zero accumulator
// skips the shifts, the root and the divider.
// One item at a time: the next item is taken in the cycle after the result leaves.
// After reset a clearing pass zeroes the accumulators; no item is taken until it ends.
module vertex_normal_accumulator
	import vna_pkg::*;
#(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	ctl_t ctl;
	sts_t sts;

	// Control.
	vna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_cmd   (in_data.command),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Data.
	vna_dp #(.VERTEX_COUNT(VERTEX_COUNT)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_data),
		.ctl     (ctl),
		.sts     (sts),
		.out_item(out_data)
	);

endmodule

@@ verif/vertex_normal_accumulator_test.sv @@
// Self-checking testbench for the vertex normal accumulator.
// Depends on vna_pkg and vertex_normal_accumulator; drives writes, triangles and reads.
module vertex_normal_accumulator_test;
	import vna_pkg::*;

	localparam int VCOUNT = VERTEX_COUNT_DEF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	vertex_normal_accumulator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Predictor state: positions and the three accumulators per vertex.
	logic signed [15:0] vert_pos [VCOUNT][3];
	logic signed [47:0] normal_sum [VCOUNT][3] = '{default: '0};

	in_item_t pending_items[$];
	out_item_t expected_normals[$];
	int error_count = 0;
	int results_seen = 0;
	int reads_sent = 0;
	int tri_sent = 0;
	bit quiet_phase = 0;
	bit stim_done = 0;
	bit in_taken = 0;

	// Clock.
	initial clk = 0;
	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Applies one item to the predictor and returns the result it produces.
	function automatic out_item_t predict_normal(input in_item_t it);
		out_item_t r;
		logic signed [63:0] e0 [3], e1 [3], cr [3];
		logic [63:0] q [3], mx, sum, len, n;
		logic signed [63:0] c [3];
		int s;
		r = '0;
		case (cmd_t'(it.command))
			CMD_WRITE: begin
				vert_pos[it.index_a][0] = it.pos_x;
				vert_pos[it.index_a][1] = it.pos_y;
				vert_pos[it.index_a][2] = it.pos_z;
				for (int k = 0; k < 3; k++) normal_sum[it.index_a][k] = '0;
			end
			CMD_TRI: begin
				for (int k = 0; k < 3; k++) begin
					e0[k] = 64'(vert_pos[it.index_b][k]) - 64'(vert_pos[it.index_a][k]);
					e1[k] = 64'(vert_pos[it.index_c][k]) - 64'(vert_pos[it.index_a][k]);
				end
				cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
				cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
				cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
				for (int k = 0; k < 3; k++) begin
					normal_sum[it.index_a][k] = normal_sum[it.index_a][k] + cr[k][47:0];
					normal_sum[it.index_b][k] = normal_sum[it.index_b][k] + cr[k][47:0];
					normal_sum[it.index_c][k] = normal_sum[it.index_c][k] + cr[k][47:0];
				end
			end
			CMD_READ: begin
				for (int k = 0; k < 3; k++) c[k] = 64'(normal_sum[it.index_a][k]);
				if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
					r.normal_z = 16'(ONE_Q14);
					r.defaulted = 1'b1;
				end else begin
					mx = 0;
					for (int k = 0; k < 3; k++) begin
						q[k] = c[k] < 0 ? 64'(-c[k]) : 64'(c[k]);
						if (q[k] > mx) mx = q[k];
					end
					s = 0;
					while ((mx >> s) >= (64'd1 << 30)) s++;
					sum = 0;
					for (int k = 0; k < 3; k++) begin
						q[k] = q[k] >> s;
						sum = sum + q[k] * q[k];
					end
					len = int_sqrt(sum);
					if (len == 0) len = 1;
					for (int k = 0; k < 3; k++) begin
						n = (q[k] * ONE_Q14 + len / 2) / len;
						if (n > ONE_Q14) n = ONE_Q14;
						if (c[k] > 0) n = -n;
						if (k == 0) r.normal_x = n[15:0];
						else if (k == 1) r.normal_y = n[15:0];
						else r.normal_z = n[15:0];
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Builders for the stimulus.
	function automatic in_item_t make_item(input cmd_t cmd, input int a, input int b,
			input int c, input int px, input int py, input int pz);
		in_item_t it;
		it.command = cmd;
		it.index_a = IDX_W'(a);
		it.index_b = IDX_W'(b);
		it.index_c = IDX_W'(c);
		it.pos_x = POS_W'(px);
		it.pos_y = POS_W'(py);
		it.pos_z = POS_W'(pz);
		return it;
	endfunction

	// Only triangles whose corners were written are queued; the shadow flags track that.
	bit planned [VCOUNT];

	function automatic int pick_written();
		int v;
		do v = $urandom_range(0, VCOUNT - 1); while (!planned[v]);
		return v;
	endfunction

	task automatic queue_item(input in_item_t it);
		if (it.command == CMD_WRITE) planned[it.index_a] = 1;
		if (it.command == CMD_READ) reads_sent++;
		if (it.command == CMD_TRI) tri_sent++;
		pending_items.push_back(it);
	endtask

	// Small coordinates keep normals meaningful; full range exercises wrap.
	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return int'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	// Stimulus generation: directed items first, then random meshes.
	initial begin
		int a, b, c, cnt;
		arst_n = 0;
		// Directed: extremes, every command, defaulted read, no-op.
		queue_item(make_item(CMD_READ, 5, 0, 0, 0, 0, 0));
		queue_item(make_item(CMD_WRITE, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(CMD_WRITE, 1, 0, 0, 32767, 0, 0));
		queue_item(make_item(CMD_WRITE, 2, 0, 0, 0, 32767, 0));
		queue_item(make_item(CMD_WRITE, 1023, 1023, 1023, -32768, -32768, -32768));
		queue_item(make_item(CMD_TRI, 0, 1, 2, 0, 0, 0));
		queue_item(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
		queue_item(make_item(CMD_READ, 1, 0, 0, 0, 0, 0));
		queue_item(make_item(CMD_TRI, 0, 2, 1, 0, 0, 0));
		queue_item(make_item(CMD_READ, 2, 0, 0, 0, 0, 0));
		queue_item(make_item(CMD_TRI, 1023, 1, 2, 0, 0, 0));
		queue_item(make_item(CMD_TRI, 1023, 1023, 1023, 0, 0, 0));
		queue_item(make_item(CMD_READ, 1023, 0, 0, 0, 0, 0));
		queue_item(make_item(CMD_NOP, 1023, 1023, 1023, -1, -1, -1));
		queue_item(make_item(CMD_WRITE, 3, 0, 0, -32768, 32767, 32767));
		queue_item(make_item(CMD_WRITE, 4, 0, 0, 32767, -32768, 32767));
		for (int k = 0; k < 40; k++) queue_item(make_item(CMD_TRI, 1, 3, 4, 0, 0, 0));
		queue_item(make_item(CMD_READ, 1, 0, 0, 0, 0, 0));
		queue_item(make_item(CMD_READ, 3, 0, 0, 0, 0, 0));
		// Random part: writes into a growing pool, triangles, reads, some noise.
		cnt = 0;
		while (cnt < 1100) begin
			case ($urandom_range(0, 9))
				0, 1: queue_item(make_item(CMD_WRITE, $urandom_range(0, VCOUNT - 1),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					rand_coord(), rand_coord(), rand_coord()));
				2, 3, 4, 5: begin
					a = pick_written();
					b = $urandom_range(0, 4) == 0 ? a : pick_written();
					c = pick_written();
					queue_item(make_item(CMD_TRI, a, b, c, $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535)));
				end
				6, 7, 8: queue_item(make_item(CMD_READ,
					$urandom_range(0, 3) == 0 ? $urandom_range(0, VCOUNT - 1) : pick_written(),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535)));
				default: queue_item(make_item(CMD_NOP, $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535)));
			endcase
			cnt++;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// Marks whether the item on the input was taken at the last rising edge.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// Driver: presents queued items, with random idle bursts.
	int in_gap = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
		end else if (in_valid && !in_taken) begin
			// Hold the stalled item.
		end else begin
			if (pending_items.size() < 150) quiet_phase = 1;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(1, 12) - 1;
				in_valid <= 0;
			end else if (pending_items.size() > 0) begin
				in_valid <= 1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 0;
				stim_done = 1;
			end
		end
	end

	// Receiver stall bursts.
	int out_gap = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1;
		end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(1, 12) - 1;
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	// Monitor: predicts on input acceptance and checks on output acceptance.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && in_valid && !in_stall)
			expected_normals.push_back(predict_normal(in_data));
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_normals.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_normals.pop_front();
				if (out_data.normal_x !== want.normal_x)
					report_mismatch("normal_x", out_data.normal_x, want.normal_x);
				if (out_data.normal_y !== want.normal_y)
					report_mismatch("normal_y", out_data.normal_y, want.normal_y);
				if (out_data.normal_z !== want.normal_z)
					report_mismatch("normal_z", out_data.normal_z, want.normal_z);
				if (out_data.defaulted !== want.defaulted)
					report_mismatch("defaulted", out_data.defaulted, want.defaulted);
			end
		end
	end

	// End of run: drain, settle, report.
	initial begin
		wait (arst_n === 1'b1);
		wait (stim_done && !in_valid);
		while (expected_normals.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Checked %0d results from %0d triangles and %0d normal reads.",
			results_seen, tri_sent, reads_sent);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
